// ----- rtl/core/spike_rate_leaky_motor_drive_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the spike-rate motor drive
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPIKE_RATE_LEAKY_MOTOR_DRIVE_DEFINES_SVH
`define SPIKE_RATE_LEAKY_MOTOR_DRIVE_DEFINES_SVH

// same-cycle implication
`define SRLMD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRLMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/srlmd_pkg.sv -----
// ----------------------------------------------------------------------------
// srlmd_pkg
// Constants shared by the spike-rate leaky motor drive.
// ----------------------------------------------------------------------------
package srlmd_pkg;

	localparam int FRAC_BITS  = 15;
	localparam int FX_W       = 32;
	localparam int PERIOD_W   = 16;
	localparam int NCOUNT_W   = 10;
	localparam int CMD_W      = 11;
	localparam int CFG_IDX_W  = 3;

	// command limit, integer and s16.15
	localparam int CMD_LIMIT = 800;
	localparam logic signed [FX_W-1:0] CMD_LIMIT_FX = FX_W'(CMD_LIMIT <<< FRAC_BITS);

	// clamped level fits 26 bits signed
	localparam int CLAMP_W = 26;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPIKE_WEIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEURON_COUNT  = 3'd4;

	// item kinds
	localparam logic ACTION_SPIKE = 1'b0;
	localparam logic ACTION_TICK  = 1'b1;

endpackage

// ----- rtl/core/spike_rate_leaky_motor_drive.sv -----
// ----------------------------------------------------------------------------
// spike_rate_leaky_motor_drive
// Spike counter and leaky integrator producing a clamped motor command.
// ----------------------------------------------------------------------------
// Use:
//  - Input channel (in_valid/in_ready, action, spike_key) takes one word per
//    item: a spike event (action 0) or a timer tick (action 1).
//  - Output channel (out_valid/out_ready, motor_command) carries one word on
//    each update tick, nothing for other items.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//    ready; write it only while the block is idle.
// Sequence:
//  - A spike, or a tick under a zero period, is handled in the idle state.
//  - Other ticks run a 32-step restoring divider (one bit per cycle) that
//    finds time mod sample_period, then a compare state.
//  - An update tick then forms three products on one shared 32x32
//    multiplier, the sum, the clamp and the command load; the next item
//    can be accepted once the command is loaded into the output register.
// Reset: all registers take their reset values at once, tick time is all
//  ones so the first tick reads as time 0; no clearing pass.
// Stall: the command sits in an output register; the block goes on taking
//  items while it waits, until a following update tick has its command
//  ready, which holds the input off until the receiver takes the old word.
// ----------------------------------------------------------------------------
`include "spike_rate_leaky_motor_drive_defines.svh"

module spike_rate_leaky_motor_drive
	import srlmd_pkg::*;
#(
	parameter int NEURON_ID_BITS = 9,
	parameter int TALLY_BITS     = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [FX_W-1:0]             cfg_data,

	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic [31:0]                 spike_key,

	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [CMD_W-1:0]     motor_command
);

	// width for the neuron id compare
	localparam int CMP_W = (NEURON_ID_BITS > NCOUNT_W) ? NEURON_ID_BITS : NCOUNT_W;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,         // one dividend bit per cycle
		S_CHECK,       // remainder == period - 1 ?
		S_MUL_DECAY,   // level * decay
		S_MUL_WEIGHT,  // tally * weight
		S_SUM,         // new level, tally cleared
		S_MUL_GAIN,    // level * gain
		S_CLAMP
	} state_t;

	state_t state_q;

	// configuration
	logic [PERIOD_W-1:0]        period_q;
	logic signed [FX_W-1:0]     decay_q;
	logic signed [FX_W-1:0]     weight_q;
	logic signed [FX_W-1:0]     gain_q;
	logic [NCOUNT_W-1:0]        ncount_q;

	// block state
	logic [31:0]                tick_time_q;
	logic [TALLY_BITS-1:0]      spike_tally_q;
	logic signed [FX_W-1:0]     level_q;

	// working registers
	logic [31:0]                dividend_q;
	logic [PERIOD_W-1:0]        rem_q;
	logic [DIV_CNT_W-1:0]       div_cnt_q;
	logic signed [63:0]         prod_q;
	logic signed [FX_W-1:0]     acc_q;
	logic signed [CLAMP_W-1:0]  clamp_q;
	logic                       emit_pend_q;
	logic                       out_valid_q;
	logic signed [CMD_W-1:0]    cmd_q;

	// ---------------------------------------------------------------- handshake
	assign cfg_ready     = 1'b1;
	assign in_ready      = (state_q == S_IDLE) && !emit_pend_q;
	assign out_valid     = out_valid_q;
	assign motor_command = cmd_q;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// ---------------------------------------------------------------- spike test
	logic id_hit;
	logic tally_full;
	assign id_hit     = CMP_W'(spike_key[NEURON_ID_BITS-1:0]) < CMP_W'(ncount_q);
	assign tally_full = (spike_tally_q == {TALLY_BITS{1'b1}});

	// ---------------------------------------------------------------- divider step
	logic [PERIOD_W:0]   rem_sh;
	logic [PERIOD_W-1:0] rem_n;
	assign rem_sh = {rem_q, dividend_q[31]};
	assign rem_n  = (rem_sh >= {1'b0, period_q}) ? PERIOD_W'(rem_sh - {1'b0, period_q})
	                                              : rem_sh[PERIOD_W-1:0];

	// ---------------------------------------------------------------- shared multiplier
	logic signed [FX_W-1:0] mul_a;
	logic signed [FX_W-1:0] mul_b;
	logic signed [63:0]     mul_p;

	always_comb begin
		unique case (state_q)
			S_MUL_DECAY: begin
				mul_a = level_q;
				mul_b = decay_q;
			end
			S_MUL_WEIGHT: begin
				mul_a = signed'(FX_W'(spike_tally_q));
				mul_b = weight_q;
			end
			S_MUL_GAIN: begin
				mul_a = level_q;
				mul_b = gain_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// s16.15 product: floor shift, low 32 bits kept
	logic signed [FX_W-1:0] prod_fx;
	assign prod_fx = prod_q[FRAC_BITS+FX_W-1:FRAC_BITS];

	// ---------------------------------------------------------------- clamp, truncate
	logic signed [CLAMP_W-1:0] clamp_n;
	always_comb begin
		priority if (prod_fx > CMD_LIMIT_FX)
			clamp_n = CLAMP_W'(CMD_LIMIT_FX);
		else if (prod_fx < -CMD_LIMIT_FX)
			clamp_n = CLAMP_W'(-CMD_LIMIT_FX);
		else
			clamp_n = CLAMP_W'(prod_fx);
	end

	// toward zero: truncate magnitude, restore sign
	logic [CLAMP_W-1:0] clamp_mag;
	logic [CMD_W-1:0]   cmd_mag;
	logic signed [CMD_W-1:0] cmd_n;
	assign clamp_mag = clamp_q[CLAMP_W-1] ? CLAMP_W'(-clamp_q) : CLAMP_W'(clamp_q);
	assign cmd_mag   = clamp_mag[CLAMP_W-1:FRAC_BITS];
	assign cmd_n     = clamp_q[CLAMP_W-1] ? signed'(CMD_W'(-cmd_mag)) : signed'(cmd_mag);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			period_q      <= PERIOD_W'(1);
			decay_q       <= '0;
			weight_q      <= '0;
			gain_q        <= '0;
			ncount_q      <= '0;
			tick_time_q   <= '1;
			spike_tally_q <= '0;
			level_q       <= '0;
			dividend_q    <= '0;
			rem_q         <= '0;
			div_cnt_q     <= '0;
			prod_q        <= '0;
			acc_q         <= '0;
			clamp_q       <= '0;
			emit_pend_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			cmd_q         <= '0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_SAMPLE_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
					REG_DECAY_FACTOR:  decay_q  <= signed'(cfg_data);
					REG_SPIKE_WEIGHT:  weight_q <= signed'(cfg_data);
					REG_OUTPUT_GAIN:   gain_q   <= signed'(cfg_data);
					REG_NEURON_COUNT:  ncount_q <= cfg_data[NCOUNT_W-1:0];
					default: ;
				endcase
			end

			// output word: taken by receiver, or a new one loaded
			if (emit_pend_q && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				cmd_q       <= cmd_n;
				emit_pend_q <= 1'b0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (action == ACTION_SPIKE) begin
							if (id_hit && !tally_full)
								spike_tally_q <= spike_tally_q + TALLY_BITS'(1);
						end else begin
							tick_time_q <= tick_time_q + 32'd1;
							dividend_q  <= tick_time_q + 32'd1;
							rem_q       <= '0;
							div_cnt_q   <= '0;
							// zero period never updates
							if (period_q != '0)
								state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q      <= rem_n;
					dividend_q <= {dividend_q[30:0], 1'b0};
					div_cnt_q  <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (rem_q == period_q - PERIOD_W'(1))
						state_q <= S_MUL_DECAY;
					else
						state_q <= S_IDLE;
				end
				S_MUL_DECAY: begin
					prod_q  <= mul_p;
					state_q <= S_MUL_WEIGHT;
				end
				S_MUL_WEIGHT: begin
					acc_q   <= prod_fx;
					prod_q  <= mul_p;
					state_q <= S_SUM;
				end
				S_SUM: begin
					// tally * weight keeps its low word, no shift
					level_q       <= acc_q + signed'(prod_q[FX_W-1:0]);
					spike_tally_q <= '0;
					state_q       <= S_MUL_GAIN;
				end
				S_MUL_GAIN: begin
					prod_q  <= mul_p;
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					clamp_q     <= clamp_n;
					emit_pend_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- checks
	`SRLMD_ASSERT_NOW(a_cmd_in_range, out_valid, ($signed(motor_command) <= CMD_LIMIT) && ($signed(motor_command) >= -CMD_LIMIT), "motor command outside clamp range")
	`SRLMD_ASSERT_NEXT(a_tick_advances, in_valid && in_ready && (action == ACTION_TICK), tick_time_q == $past(tick_time_q) + 32'd1, "tick did not advance time")
	`SRLMD_ASSERT_NEXT(a_tally_cleared, state_q == S_SUM, spike_tally_q == '0, "tally not cleared on update")
	`SRLMD_ASSERT_NOW(a_no_accept_pending, emit_pend_q, !in_ready, "item accepted while command load pending")

endmodule
